FILE: hw/rtl/dtm_pkg.sv
// dtm_pkg: shared widths, constants, register codes and types for the
// four-motor roll/pitch mixer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dtm_pkg;

  // field widths
  localparam int RAW_W   = 15;  // Q7.8 percent input
  localparam int GAIN_W  = 10;  // Q2.8 gain
  localparam int PCT_W   = 7;   // whole percent output
  localparam int CFG_W   = 15;  // widest register
  localparam int IDX_W   = 2;   // register index

  // internal widths
  localparam int CTR_W   = 17;  // re-centred and doubled stick, signed
  localparam int STICK_W = 16;  // clamped stick, +/-25600, signed
  localparam int PROD_W  = STICK_W + GAIN_W + 1;  // stick times gain, signed
  localparam int TERM_W  = 18;  // scaled term, +/-102300, signed
  localparam int SUM_W   = 19;  // motor sum, signed

  // percent constants on the Q7.8 scale
  localparam logic [RAW_W-1:0]        PCT_FULL    = 15'd25600;
  localparam logic signed [CTR_W-1:0] PCT_CENTRE  = 17'sd12800;
  localparam logic signed [CTR_W-1:0] STICK_MAX   = 17'sd25600;
  localparam logic signed [CTR_W-1:0] STICK_MIN   = -17'sd25600;
  localparam logic signed [SUM_W-1:0] MOTOR_MAX   = 19'sd25600;

  // register reset values
  localparam logic [CFG_W-1:0]  FLOOR_RST    = 15'd0;
  localparam logic [CFG_W-1:0]  CEIL_RST     = 15'd25600;
  localparam logic [GAIN_W-1:0] GAIN_RST     = 10'd256;
  localparam logic [CFG_W-1:0]  DEADBAND_RST = 15'd1280;

  // register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_THR_FLOOR  = 2'd0,
    REG_THR_CEIL   = 2'd1,
    REG_STICK_GAIN = 2'd2,
    REG_DEADBAND   = 2'd3
  } cfg_idx_t;

  // register file contents
  typedef struct packed {
    logic [CFG_W-1:0]  thr_floor;
    logic [CFG_W-1:0]  thr_ceil;
    logic [GAIN_W-1:0] stick_gain;
    logic [CFG_W-1:0]  deadband;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dtm_cfg_regs.sv
// dtm_cfg_regs: configuration register file of the mixer.
// Depends on dtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtm_cfg_regs (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [dtm_pkg::IDX_W-1:0] cfg_idx,
  input  wire logic [dtm_pkg::CFG_W-1:0] cfg_wdata,
  output dtm_pkg::cfg_t              cfg
);
  import dtm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // decode writes, dropping bits beyond each register
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        REG_THR_FLOOR:  cfg_nxt.thr_floor  = cfg_wdata;
        REG_THR_CEIL:   cfg_nxt.thr_ceil   = cfg_wdata;
        REG_STICK_GAIN: cfg_nxt.stick_gain = cfg_wdata[GAIN_W-1:0];
        REG_DEADBAND:   cfg_nxt.deadband   = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.thr_floor  <= FLOOR_RST;
      cfg_r.thr_ceil   <= CEIL_RST;
      cfg_r.stick_gain <= GAIN_RST;
      cfg_r.deadband   <= DEADBAND_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: hw/rtl/dtm_stick_term.sv
// dtm_stick_term: re-centres one stick channel, clamps it to +/-100 percent
// and scales it by the Q2.8 gain with floor rounding. Depends on dtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtm_stick_term (
  input  wire logic [dtm_pkg::RAW_W-1:0]         raw,
  input  wire logic [dtm_pkg::GAIN_W-1:0]        gain,
  output logic signed [dtm_pkg::TERM_W-1:0]      term
);
  import dtm_pkg::*;

  logic signed [CTR_W-1:0]   centred;
  logic signed [CTR_W-1:0]   doubled;
  logic signed [STICK_W-1:0] clamped;
  logic signed [PROD_W-1:0]  product;

  // (raw - 50%) * 2, fits 17 bits signed
  assign centred = $signed({2'b00, raw}) - PCT_CENTRE;
  assign doubled = centred <<< 1;

  // saturate to +/-100%
  always_comb begin
    if (doubled < STICK_MIN) begin
      clamped = STICK_MIN[STICK_W-1:0];
    end else if (doubled > STICK_MAX) begin
      clamped = STICK_MAX[STICK_W-1:0];
    end else begin
      clamped = doubled[STICK_W-1:0];
    end
  end

  // scale by gain, arithmetic shift gives floor
  assign product = PROD_W'(clamped) * $signed({1'b0, gain});
  assign term    = product[TERM_W+7:8];

endmodule

`default_nettype wire

FILE: hw/rtl/dtm_motor_out.sv
// dtm_motor_out: clamps one motor sum to 0..100 percent, applies the
// deadband and truncates to whole percent. Depends on dtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtm_motor_out (
  input  wire logic signed [dtm_pkg::SUM_W-1:0] sum,
  input  wire logic [dtm_pkg::CFG_W-1:0]        deadband,
  output logic [dtm_pkg::PCT_W-1:0]             pct
);
  import dtm_pkg::*;

  logic [RAW_W-1:0] sat;
  logic [RAW_W-1:0] gated;

  // saturate to 0..100%
  always_comb begin
    if (sum < 0) begin
      sat = '0;
    end else if (sum > MOTOR_MAX) begin
      sat = PCT_FULL;
    end else begin
      sat = sum[RAW_W-1:0];
    end
  end

  // values strictly inside the deadband are cut to zero
  assign gated = ((sat != '0) && (sat < deadband)) ? '0 : sat;

  // whole percent, truncated
  assign pct = gated[RAW_W-1:8];

endmodule

`default_nettype wire

FILE: hw/rtl/differential_thrust_motor_mixer.sv
// differential_thrust_motor_mixer: top level of the four-motor mixer.
// Depends on dtm_pkg, dtm_cfg_regs, dtm_stick_term and dtm_motor_out.
`timescale 1ns / 1ps
`default_nettype none

// Four-motor roll/pitch mixer. Each request carries throttle, roll and pitch
// in Q7.8 percent and yields one result of four whole-percent motor drives
// (left outer t+r+p, left inner t+r-p, right inner t-r-p, right outer t-r+p).
// The block is a two-register pipeline: a request is captured in an input
// register, mixed by one pass of logic (one 16x11 multiply per stick
// channel, adds and clamps) and held in a result register. out_valid is
// the valid bit of the result register; the result is taken at a rising edge
// where out_valid is high and out_stall low. One request is taken every cycle
// while out_stall stays low; in_stall rises only when both registers are
// full and the result side is stalling. Configuration registers are written
// through cfg_we/cfg_idx/cfg_wdata and must only change while the pipeline
// is empty.
module differential_thrust_motor_mixer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [dtm_pkg::IDX_W-1:0]   cfg_idx,
  input  wire logic [dtm_pkg::CFG_W-1:0]   cfg_wdata,
  // stick requests
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [dtm_pkg::RAW_W-1:0]   in_throttle_raw,
  input  wire logic [dtm_pkg::RAW_W-1:0]   in_roll_raw,
  input  wire logic [dtm_pkg::RAW_W-1:0]   in_pitch_raw,
  // motor results
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [dtm_pkg::PCT_W-1:0]        out_left_outer_pct,
  output logic [dtm_pkg::PCT_W-1:0]        out_left_inner_pct,
  output logic [dtm_pkg::PCT_W-1:0]        out_right_inner_pct,
  output logic [dtm_pkg::PCT_W-1:0]        out_right_outer_pct
);
  import dtm_pkg::*;

  cfg_t cfg;

  logic             s1_valid_r;
  logic [RAW_W-1:0] thr_r;
  logic [RAW_W-1:0] roll_r;
  logic [RAW_W-1:0] pitch_r;

  logic             out_valid_r;
  logic [PCT_W-1:0] lo_r, li_r, ri_r, ro_r;
  logic [PCT_W-1:0] lo_nxt, li_nxt, ri_nxt, ro_nxt;

  logic out_en;
  logic s1_en;

  logic [RAW_W-1:0]         thr_clamped;
  logic signed [TERM_W-1:0] roll_term;
  logic signed [TERM_W-1:0] pitch_term;
  logic signed [SUM_W-1:0]  t_ext, r_ext, p_ext;
  logic signed [SUM_W-1:0]  sum_lo, sum_li, sum_ri, sum_ro;

  dtm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // pipeline enables
  assign out_en   = !out_valid_r || !out_stall;
  assign s1_en    = !s1_valid_r || out_en;
  assign in_stall = !s1_en;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      thr_r   <= in_throttle_raw;
      roll_r  <= in_roll_raw;
      pitch_r <= in_pitch_raw;
    end
  end

  // throttle clamp, floor tested first
  always_comb begin
    if (thr_r < cfg.thr_floor) begin
      thr_clamped = cfg.thr_floor;
    end else if (thr_r > cfg.thr_ceil) begin
      thr_clamped = cfg.thr_ceil;
    end else begin
      thr_clamped = thr_r;
    end
  end

  dtm_stick_term u_roll (
    .raw  (roll_r),
    .gain (cfg.stick_gain),
    .term (roll_term)
  );

  dtm_stick_term u_pitch (
    .raw  (pitch_r),
    .gain (cfg.stick_gain),
    .term (pitch_term)
  );

  // motor mix
  assign t_ext  = $signed({{(SUM_W-RAW_W){1'b0}}, thr_clamped});
  assign r_ext  = SUM_W'(roll_term);
  assign p_ext  = SUM_W'(pitch_term);
  assign sum_lo = t_ext + r_ext + p_ext;
  assign sum_li = t_ext + r_ext - p_ext;
  assign sum_ri = t_ext - r_ext - p_ext;
  assign sum_ro = t_ext - r_ext + p_ext;

  dtm_motor_out u_lo (.sum(sum_lo), .deadband(cfg.deadband), .pct(lo_nxt));
  dtm_motor_out u_li (.sum(sum_li), .deadband(cfg.deadband), .pct(li_nxt));
  dtm_motor_out u_ri (.sum(sum_ri), .deadband(cfg.deadband), .pct(ri_nxt));
  dtm_motor_out u_ro (.sum(sum_ro), .deadband(cfg.deadband), .pct(ro_nxt));

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      lo_r <= lo_nxt;
      li_r <= li_nxt;
      ri_r <= ri_nxt;
      ro_r <= ro_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_left_outer_pct  = lo_r;
  assign out_left_inner_pct  = li_r;
  assign out_right_inner_pct = ri_r;
  assign out_right_outer_pct = ro_r;

endmodule

`default_nettype wire
